[hdl/fac_pkg.sv]
// Shared types and constants for the fully associative tag cache.
// No dependencies; every other file of the block imports this package.
package fac_pkg;

  localparam int NUM_ENTRIES_DEF = 16;
  localparam int TAG_BITS_DEF    = 48;

  localparam int ADDR_W     = 48;
  localparam int CNT_W      = 32;
  localparam int EIU_W      = 5;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 8;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_POLICY  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ENTRIES = CFG_IDX_W'(1);

  // replacement policy codes
  localparam logic POLICY_FIFO = 1'b0;
  localparam logic POLICY_LRU  = 1'b1;

  localparam logic [EIU_W-1:0] EIU_RESET = EIU_W'(16);

  // per-cycle command broadcast to every cell of the tag chain
  typedef struct packed {
    logic cmp_en;     // latch compare result against the key
    logic shift_all;  // every cell takes its younger neighbor (drop oldest)
    logic shift_hit;  // cells at or past the hit take their younger neighbor
    logic load_en;    // write the key into the target cell
    logic load_tail;  // target is the youngest valid cell, else first free cell
  } fac_ctrl_t;

endpackage

[hdl/fac_if.sv]
// Handshake channels of the tag cache: input word, result word, config write.
// Depends on fac_pkg for payload widths.
interface fac_in_if import fac_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] address_tag;

  modport source (output valid, output address_tag, input ready);
  modport sink   (input valid, input address_tag, output ready);
endinterface

interface fac_out_if import fac_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             hit;
  logic [CNT_W-1:0] access_total;
  logic [CNT_W-1:0] miss_total;

  modport source (output valid, output hit, output access_total, output miss_total,
                  input ready);
  modport sink   (input valid, input hit, input access_total, input miss_total,
                  output ready);
endinterface

interface fac_cfg_if import fac_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[hdl/fac_cell.sv]
// One entry of the ordered tag list: holds a tag, compares it, shifts it.
// Depends on fac_pkg for the command struct.
module fac_cell import fac_pkg::*; #(
  parameter int IDX      = 0,
  parameter int TAG_BITS = TAG_BITS_DEF,
  parameter int OCC_W    = 5
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fac_ctrl_t           ctrl_i,
  input  logic [OCC_W-1:0]    occ_i,
  input  logic [TAG_BITS-1:0] key_i,
  input  logic [TAG_BITS-1:0] nbr_tag_i,
  input  logic                seen_i,
  output logic [TAG_BITS-1:0] tag_o,
  output logic                seen_o,
  output logic                match_o
);

  logic [TAG_BITS-1:0] tag_q, tag_d;
  logic                match_q, match_d;
  logic                active;
  logic                target;

  assign active = OCC_W'(IDX) < occ_i;
  // load target: youngest valid cell on a hit, first free cell on a miss
  assign target = ctrl_i.load_tail ? (OCC_W'(IDX + 1) == occ_i) : (OCC_W'(IDX) == occ_i);

  assign seen_o  = seen_i | match_q;
  assign match_o = match_q;
  assign tag_o   = tag_q;

  always_comb begin
    match_d = match_q;
    if (ctrl_i.cmp_en) begin
      match_d = active && (tag_q == key_i);
    end
  end

  always_comb begin
    tag_d = tag_q;
    if (ctrl_i.load_en && target) begin
      tag_d = key_i;
    end else if (ctrl_i.shift_all || (ctrl_i.shift_hit && seen_o)) begin
      tag_d = nbr_tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q <= tag_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else begin
      match_q <= match_d;
    end
  end

endmodule

[hdl/fac_chain.sv]
// Row of tag cells, oldest at index 0, each but the youngest fed by its younger neighbor.
// Depends on fac_pkg and fac_cell.
module fac_chain import fac_pkg::*; #(
  parameter int NUM_ENTRIES = NUM_ENTRIES_DEF,
  parameter int TAG_BITS    = TAG_BITS_DEF,
  parameter int OCC_W       = 5
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  fac_ctrl_t              ctrl_i,
  input  logic [OCC_W-1:0]       occ_i,
  input  logic [TAG_BITS-1:0]    key_i,
  output logic [NUM_ENTRIES-1:0] match_o
);

  logic [TAG_BITS-1:0] tag  [NUM_ENTRIES];
  logic [TAG_BITS-1:0] nbr  [NUM_ENTRIES];
  logic [NUM_ENTRIES:0] seen;

  assign seen[0] = 1'b0;

  for (genvar k = 0; k < NUM_ENTRIES; k++) begin : g_cell
    // youngest cell has no neighbor: hold its own value
    if (k == NUM_ENTRIES - 1) begin : g_last
      assign nbr[k] = tag[k];
    end else begin : g_mid
      assign nbr[k] = tag[k+1];
    end

    fac_cell #(
      .IDX      (k),
      .TAG_BITS (TAG_BITS),
      .OCC_W    (OCC_W)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl_i),
      .occ_i     (occ_i),
      .key_i     (key_i),
      .nbr_tag_i (nbr[k]),
      .seen_i    (seen[k]),
      .tag_o     (tag[k]),
      .seen_o    (seen[k+1]),
      .match_o   (match_o[k])
    );
  end

endmodule

[hdl/fully_assoc_cache_lru_fifo_top.sv]
// Top level of the fully associative tag cache with FIFO or LRU replacement.
// Depends on fac_pkg, the fac_*_if interfaces and fac_chain.
//
//   channel | dir | payload                              | accepted when
//   --------+-----+--------------------------------------+------------------------
//   in_i    | in  | address_tag                          | valid && ready
//   out_o   | out | hit, access_total, miss_total        | valid && ready
//   cfg_i   | in  | index (0 policy, 1 entries), data    | valid && ready (always)
//
// Sequence per word: accept, parallel compare in every cell, list update,
// result write. The next word is taken only after the result write. On a
// miss with no room the update step first drops the oldest entry, one per
// cycle, since the chain shifts one place per cycle, until there is room: a
// miss on a full list drops one, and a miss after capacity was lowered below
// occupancy drops one more per further entry over capacity.
// Reset: async, active low; clears occupancy, counters and the control state.
// Stalls: a result waits in the output register; the block finishes the next
// word's update meanwhile and holds it in the write step until out_o drains.
module fully_assoc_cache_lru_fifo_top import fac_pkg::*; #(
  parameter int NUM_ENTRIES = NUM_ENTRIES_DEF,
  parameter int TAG_BITS    = TAG_BITS_DEF
) (
  input logic        clk_i,
  input logic        rst_ni,
  fac_in_if.sink     in_i,
  fac_out_if.source  out_o,
  fac_cfg_if.sink    cfg_i
);

  localparam int OCC_W = $clog2(NUM_ENTRIES + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CMP   = 2'd1;
  localparam logic [1:0] ST_EVICT = 2'd2;
  localparam logic [1:0] ST_WRITE = 2'd3;

  logic [1:0]             state_q, state_d;
  logic [TAG_BITS-1:0]    key_q;
  logic [OCC_W-1:0]       occ_q, occ_d;
  logic [CNT_W-1:0]       acc_q, acc_d;
  logic [CNT_W-1:0]       miss_q, miss_d;
  logic                   hit_q;
  logic                   out_valid_q;
  logic                   policy_q;
  logic [EIU_W-1:0]       eiu_q;

  logic [NUM_ENTRIES-1:0] match;
  logic                   hit;
  logic [OCC_W-1:0]       cap;
  fac_ctrl_t              ctrl;
  logic                   in_fire;
  logic                   load_out;

  // ---------------------------------------------------------------------------
  // configuration: always ready; to be written only while idle, which the block does not enforce
  // ---------------------------------------------------------------------------
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= POLICY_LRU;
      eiu_q    <= EIU_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_POLICY:  policy_q <= cfg_i.data[0];
        REG_ENTRIES: eiu_q    <= cfg_i.data[EIU_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp capacity: zero acts as one, anything past the store acts as full
  always_comb begin
    if (eiu_q == '0) begin
      cap = OCC_W'(1);
    end else if (int'(eiu_q) > NUM_ENTRIES) begin
      cap = OCC_W'(NUM_ENTRIES);
    end else begin
      cap = OCC_W'(eiu_q);
    end
  end

  // ---------------------------------------------------------------------------
  // tag chain
  // ---------------------------------------------------------------------------
  fac_chain #(
    .NUM_ENTRIES (NUM_ENTRIES),
    .TAG_BITS    (TAG_BITS),
    .OCC_W       (OCC_W)
  ) u_chain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .occ_i   (occ_q),
    .key_i   (key_q),
    .match_o (match)
  );

  // tags are unique in the list, so at most one cell matches
  assign hit = |match;

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign load_out   = (state_q == ST_WRITE) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d = state_q;
    occ_d   = occ_q;
    ctrl    = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        ctrl.cmp_en = 1'b1;
        state_d     = ST_EVICT;
      end
      ST_EVICT: begin
        if (hit) begin
          // LRU: close the gap at the hit and put the tag at the young end
          if (policy_q == POLICY_LRU) begin
            ctrl.shift_hit = 1'b1;
            ctrl.load_en   = 1'b1;
            ctrl.load_tail = 1'b1;
          end
          state_d = ST_WRITE;
        end else if (occ_q >= cap) begin
          // drop the oldest, one per cycle until there is room
          ctrl.shift_all = 1'b1;
          occ_d          = occ_q - OCC_W'(1);
        end else begin
          ctrl.load_en = 1'b1;
          occ_d        = occ_q + OCC_W'(1);
          state_d      = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // saturating counters advance as the result is written
  always_comb begin
    acc_d  = acc_q;
    miss_d = miss_q;
    if (load_out) begin
      if (acc_q != COUNT_MAX) begin
        acc_d = acc_q + CNT_W'(1);
      end
      if (!hit && miss_q != COUNT_MAX) begin
        miss_d = miss_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      key_q <= TAG_BITS'(in_i.address_tag);
    end
    if (load_out) begin
      hit_q <= hit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      occ_q       <= '0;
      acc_q       <= '0;
      miss_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      occ_q   <= occ_d;
      acc_q   <= acc_d;
      miss_q  <= miss_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // counters change only when a new result is loaded, so they hold while stalled
  assign out_o.valid        = out_valid_q;
  assign out_o.hit          = hit_q;
  assign out_o.access_total = acc_q;
  assign out_o.miss_total   = miss_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_one_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(match))
    else $error("more than one cell matched the key");

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OCC_W'(NUM_ENTRIES))
    else $error("occupancy beyond the store");

  a_miss_le_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    miss_q <= acc_q)
    else $error("miss count passed access count");

  a_hit_keeps_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && hit) |=> $stable(miss_q))
    else $error("miss count moved on a hit");

  a_hit_keeps_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EVICT && hit) |=> $stable(occ_q))
    else $error("occupancy changed on a hit");

endmodule

[tb/sv/fully_assoc_cache_lru_fifo_top_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for fully_assoc_cache_lru_fifo_top: drives address words,
// predicts hit and counters per word, and checks every result word in order.
// Depends on fac_pkg, the fac_*_if interfaces and the block's RTL.
module fully_assoc_cache_lru_fifo_top_tb;
  import fac_pkg::*;

  localparam int CLK_HALF         = 5;
  localparam int SETTLE_CYCLES    = 24;     // accept, compare, update and write steps plus up to 16 drop shifts
  localparam int CYCLE_LIMIT      = 200000;
  localparam int RANDOM_PHASES    = 7;
  localparam int PHASE_WORDS      = 82;
  localparam int LONG_HOLD_AFTER  = 150;    // results seen before the long receiver stall
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int MAX_PRINTED      = 40;

  typedef struct packed {
    logic             hit;
    logic [CNT_W-1:0] access_total;
    logic [CNT_W-1:0] miss_total;
  } access_result_t;

  logic clk_i;
  logic rst_ni;

  fac_in_if  in_if ();
  fac_out_if out_if ();
  fac_cfg_if cfg_if ();

  fully_assoc_cache_lru_fifo_top DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // Shadow copy of the cache: resident tags oldest first, counters and registers.
  logic [ADDR_W-1:0] resident_tags[$];
  logic [CNT_W-1:0]  access_cnt  = '0;
  logic [CNT_W-1:0]  miss_cnt    = '0;
  logic              policy_cfg  = POLICY_LRU;
  logic [EIU_W-1:0]  entries_cfg = EIU_RESET;

  logic [ADDR_W-1:0] pending_tags[$];      // words waiting for the driver
  access_result_t    expected_results[$];  // predictions waiting for a result word

  bit tag_taken;
  bit result_taken;
  int send_gap;
  int send_calm;
  int recv_gap;
  int recv_calm;
  int hold_left;
  bit long_hold_done;
  int results_seen;
  int mismatch_count;
  int cycle_count;

  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // Per-word random wait; now and then start a calm stretch with no waits.
  function automatic int draw_wait(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) calm_left = $urandom_range(10, 40);
    return $urandom_range(0, 9);
  endfunction

  function automatic logic [ADDR_W-1:0] rand_tag();
    return ADDR_W'({$urandom, $urandom});
  endfunction

  // Look the tag up, update order and counters, return the result it must produce.
  function automatic access_result_t lookup_and_update(input logic [ADDR_W-1:0] tag);
    int             cap;
    int             pos;
    bit             found;
    access_result_t res;
    cap = int'(entries_cfg);
    if (cap < 1) cap = 1;
    if (cap > NUM_ENTRIES_DEF) cap = NUM_ENTRIES_DEF;
    found = 1'b0;
    pos   = 0;
    for (int k = 0; k < resident_tags.size(); k++) begin
      if (!found && resident_tags[k] == tag) begin
        found = 1'b1;
        pos   = k;
      end
    end
    if (access_cnt != COUNT_MAX) access_cnt++;
    if (found) begin
      // LRU: move to youngest place; FIFO: keep the order
      if (policy_cfg == POLICY_LRU) begin
        resident_tags.delete(pos);
        resident_tags.insert(resident_tags.size(), tag);
      end
    end else begin
      if (miss_cnt != COUNT_MAX) miss_cnt++;
      // drop oldest until there is room; also trims after capacity was lowered
      while (resident_tags.size() >= cap && resident_tags.size() > 0)
        void'(resident_tags.pop_front());
      if (resident_tags.size() < NUM_ENTRIES_DEF)
        resident_tags.insert(resident_tags.size(), tag);
    end
    res.hit          = found;
    res.access_total = access_cnt;
    res.miss_total   = miss_cnt;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED)
      $display("ERROR %0t: %0s got 0x%0h want 0x%0h", $time, what, got, want);
  endtask

  // Input side: hold an offered word until taken, then wait the drawn gap.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || tag_taken) begin
      if (send_gap != 0) begin
        in_if.valid <= 1'b0;
        send_gap--;
      end else if (pending_tags.size() != 0) begin
        in_if.valid       <= 1'b1;
        in_if.address_tag <= pending_tags.pop_front();
        send_gap = draw_wait(send_calm);
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Output side: drop ready for the drawn gap after each word, plus one long
  // stall so the block backs up and stalls its input.
  always @(negedge clk_i) begin
    if (!long_hold_done && results_seen >= LONG_HOLD_AFTER) begin
      hold_left      = LONG_HOLD_CYCLES;
      long_hold_done = 1'b1;
    end
    if (hold_left != 0) begin
      out_if.ready <= 1'b0;
      hold_left--;
    end else if (result_taken) begin
      recv_gap = draw_wait(recv_calm);
      out_if.ready <= (recv_gap == 0);
      if (recv_gap != 0) recv_gap--;
    end else if (recv_gap != 0) begin
      out_if.ready <= 1'b0;
      recv_gap--;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // Sample both handshakes at the rising edge: predict on input, check on output.
  always @(posedge clk_i) begin
    access_result_t want;
    tag_taken    = rst_ni && in_if.valid && in_if.ready;
    result_taken = rst_ni && out_if.valid && out_if.ready;
    if (tag_taken)
      expected_results.insert(expected_results.size(),
                              lookup_and_update(in_if.address_tag));
    if (result_taken) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result, access_total", 64'(out_if.access_total), '0);
      end else begin
        want = expected_results.pop_front();
        if (out_if.hit !== want.hit)
          report_mismatch("hit", 64'(out_if.hit), 64'(want.hit));
        if (out_if.access_total !== want.access_total)
          report_mismatch("access_total", 64'(out_if.access_total),
                          64'(want.access_total));
        if (out_if.miss_total !== want.miss_total)
          report_mismatch("miss_total", 64'(out_if.miss_total), 64'(want.miss_total));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Wait until every word is sent and answered, then let the pipe settle.
  task automatic wait_idle();
    while (pending_tags.size() != 0 || in_if.valid || expected_results.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    // mirror the write: policy takes bit 0, entries the low five bits
    if (idx == REG_POLICY) policy_cfg = value[0];
    else if (idx == REG_ENTRIES) entries_cfg = value[EIU_W-1:0];
  endtask

  // Write both registers once the block is idle; upper data bits are don't-care.
  task automatic set_regs(input logic [CFG_DATA_W-1:0] policy_data,
                          input logic [CFG_DATA_W-1:0] entries_data);
    wait_idle();
    write_reg(REG_POLICY, policy_data);
    write_reg(REG_ENTRIES, entries_data);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  initial begin
    logic [ADDR_W-1:0] tag_pool[$];
    logic              pol;
    logic [EIU_W-1:0]  eiu;
    int                cap;

    rst_ni            = 1'b0;
    in_if.valid       = 1'b0;
    in_if.address_tag = '0;
    out_if.ready      = 1'b0;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = '0;
    cfg_if.data       = '0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset setting (LRU, 16): extreme tags, then hits that reorder the list.
    pending_tags = '{48'h0, 48'hFFFF_FFFF_FFFF, 48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555,
                     48'h0, 48'hAAAA_AAAA_AAAA};

    // Single entry under FIFO: every new tag evicts the previous one.
    set_regs(8'hFE, 8'h01);
    pending_tags = '{48'h1, 48'h1, 48'h2, 48'h1};

    // Zero entries must behave as one.
    set_regs(8'hFE, 8'hE0);
    pending_tags = '{48'h3, 48'h3, 48'h4};

    // Entries above the store clamp to its size; fill part of it under LRU.
    set_regs(8'h01, 8'hFF);
    pending_tags = '{48'd10, 48'd11, 48'd12, 48'd13, 48'd14, 48'd15};

    // Lower capacity below occupancy: a hit keeps the list, the next miss trims it.
    set_regs(8'h01, 8'h03);
    pending_tags = '{48'd12, 48'd20};

    // Switch to FIFO with the list kept: a hit on the oldest does not save it.
    set_regs(8'h00, 8'h03);
    pending_tags = '{48'd15, 48'd30, 48'd15};

    // Random phases: most words from a small pool sized near the capacity so hits
    // and evictions both happen, the rest fully random tags.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: begin pol = POLICY_LRU;  eiu = 5'd16; end
        1: begin pol = POLICY_FIFO; eiu = 5'd1;  end
        2: begin pol = POLICY_LRU;  eiu = 5'd0;  end
        3: begin pol = POLICY_FIFO; eiu = 5'd16; end
        4: begin pol = POLICY_LRU;  eiu = 5'd31; end
        default: begin
          pol = logic'($urandom_range(0, 1));
          eiu = EIU_W'($urandom_range(0, 31));
        end
      endcase
      set_regs({7'($urandom), pol}, {3'($urandom), eiu});

      cap = (eiu == 0) ? 1 : (eiu > NUM_ENTRIES_DEF) ? NUM_ENTRIES_DEF : int'(eiu);
      tag_pool.delete();
      repeat ($urandom_range(1, cap + 4)) begin
        case ($urandom_range(0, 9))
          0:       tag_pool.insert(tag_pool.size(), '0);
          1:       tag_pool.insert(tag_pool.size(), '1);
          default: tag_pool.insert(tag_pool.size(), rand_tag());
        endcase
      end

      for (int n = 0; n < PHASE_WORDS; n++) begin
        // halfway through one phase, pause the sender until all results are in
        if (ph == 3 && n == PHASE_WORDS / 2) wait_idle();
        if ($urandom_range(0, 99) < 85)
          pending_tags.insert(pending_tags.size(),
                              tag_pool[$urandom_range(0, tag_pool.size() - 1)]);
        else
          pending_tags.insert(pending_tags.size(), rand_tag());
      end
    end

    wait_idle();
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/fac_pkg.sv
hdl/fac_if.sv
hdl/fac_cell.sv
hdl/fac_chain.sv
hdl/fully_assoc_cache_lru_fifo_top.sv
tb/sv/fully_assoc_cache_lru_fifo_top_tb.sv
